// ===== rtl/ata_pkg.sv =====
// Package for the accelerometer tilt angle block: types, widths and the
// CORDIC arctangent table in degrees. No dependencies.
package ata_pkg;

  localparam int unsigned CordicStagesDefault = 16;
  localparam int unsigned CordicStagesMax     = 24;

  // 2^31 start value grows by the CORDIC gain (< 1.65), so x needs 33 bits
  // plus sign; y stays inside the same range.
  localparam int unsigned XyW    = 34;
  localparam int unsigned AngleW = 24;
  localparam int unsigned OutW   = 15;

  localparam logic signed [AngleW-1:0] AngleMaxQ16 = AngleW'(90 * 65536);
  localparam logic signed [AngleW-1:0] RoundHalf   = AngleW'(256);
  localparam logic signed [OutW-1:0]   AngleLimit  = OutW'(11520);

  // round(atan(2^-i) in degrees * 2^16)
  localparam logic signed [AngleW-1:0] AtanDegQ16 [CordicStagesMax] = '{
    24'sd2949120, 24'sd1740967, 24'sd919879, 24'sd466945, 24'sd234379,
    24'sd117304,  24'sd58666,   24'sd29335,  24'sd14668,  24'sd7334,
    24'sd3667,    24'sd1833,    24'sd917,    24'sd458,    24'sd229,
    24'sd115,     24'sd57,      24'sd29,     24'sd14,     24'sd7,
    24'sd4,       24'sd2,       24'sd1,      24'sd0
  };

  typedef struct packed {
    logic signed [XyW-1:0]    x;
    logic signed [XyW-1:0]    y;
    logic signed [AngleW-1:0] a;
    logic                     zero_num;
    logic                     zero_den;
    logic                     neg;
  } ata_lane_t;

  typedef struct packed {
    ata_lane_t pitch;
    ata_lane_t roll;
  } ata_word_t;

endpackage

// ===== rtl/accel_tilt_angle_top.sv =====
// Accelerometer tilt: pitch = atan(x/z), roll = atan(y/z) in 1/128 degree.
// Every CORDIC cell is a register stage between input acceptance and output valid:
// the first cell loads at the accepting edge, and the rounding register follows the last.
// Throughput is one word per cycle; the whole pipeline stalls together only
// while the output register holds a word that has not been taken.
// Reset (rst_ni low, asynchronous) clears all valid flags; data registers
// are not reset. The block keeps no state between words.
module accel_tilt_angle_top #(
  parameter int unsigned CORDIC_STAGES = ata_pkg::CordicStagesDefault
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic signed [15:0]              accel_x_i,
  input  logic signed [15:0]              accel_y_i,
  input  logic signed [15:0]              accel_z_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic signed [ata_pkg::OutW-1:0] pitch_angle_o,
  output logic signed [ata_pkg::OutW-1:0] roll_angle_o
);
  import ata_pkg::*;

  // Builds the starting CORDIC vector from magnitudes of numerator and z.
  // The sign of the result and the two degenerate cases travel as flags.
  function automatic ata_lane_t prepare(logic signed [15:0] num,
                                        logic signed [15:0] den);
    logic signed [17:0] ns;
    logic signed [17:0] ds;
    logic [16:0]        n;
    logic [16:0]        d;
    ata_lane_t          l;
    ns = 18'(num);
    ds = 18'(den);
    n  = 17'(ns < 0 ? -ns : ns);
    d  = 17'(ds < 0 ? -ds : ds);
    l.x        = XyW'({d, 16'b0});
    l.y        = XyW'({n, 16'b0});
    l.a        = '0;
    l.zero_num = (num == '0);
    l.zero_den = (den == '0);
    // With a zero z the angle takes the sign of the numerator alone.
    l.neg      = (den == '0) ? num[15] : (num[15] ^ den[15]);
    return l;
  endfunction

  // A single enable moves every cell at once. The pipeline only has to wait
  // when the output register is full and the consumer is not taking it.
  logic en;
  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  logic      chain_valid [CORDIC_STAGES+1];
  ata_word_t chain_word  [CORDIC_STAGES+1];

  assign chain_valid[0]      = in_valid_i;
  assign chain_word[0].pitch = prepare(accel_x_i, accel_z_i);
  assign chain_word[0].roll  = prepare(accel_y_i, accel_z_i);

  // The row of cells: cell i performs rotation i of both angles.
  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
    ata_cell #(
      .STAGE (i)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (chain_valid[i]),
      .word_i  (chain_word[i]),
      .valid_o (chain_valid[i+1]),
      .word_o  (chain_word[i+1])
    );
  end

  // Final rounding, clamping and sign; this is the output register.
  ata_final u_final (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (chain_valid[CORDIC_STAGES]),
    .word_i  (chain_word[CORDIC_STAGES]),
    .valid_o (out_valid_o),
    .pitch_o (pitch_angle_o),
    .roll_o  (roll_angle_o)
  );

endmodule

// ===== rtl/ata_cell.sv =====
// One CORDIC vectoring cell: a single rotation step for the pitch and the
// roll lane, registered. Depends on ata_pkg.
module ata_cell #(
  parameter int unsigned STAGE = 0
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  ata_pkg::ata_word_t word_i,
  output logic              valid_o,
  output ata_pkg::ata_word_t word_o
);
  import ata_pkg::*;

  function automatic ata_lane_t rotate(ata_lane_t l);
    logic signed [XyW-1:0]    xo;
    logic signed [XyW-1:0]    yo;
    logic signed [AngleW-1:0] ao;
    ata_lane_t                r;
    xo = l.x;
    yo = l.y;
    ao = l.a;
    r  = l;
    if (yo >= 0) begin
      r.x = xo + (yo >>> STAGE);
      r.y = yo - (xo >>> STAGE);
      r.a = ao + AtanDegQ16[STAGE];
    end else begin
      r.x = xo - (yo >>> STAGE);
      r.y = yo + (xo >>> STAGE);
      r.a = ao - AtanDegQ16[STAGE];
    end
    return r;
  endfunction

  logic      valid_q;
  ata_word_t word_d, word_q;

  always_comb begin
    word_d.pitch = rotate(word_i.pitch);
    word_d.roll  = rotate(word_i.roll);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      word_q <= word_d;
    end
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;

endmodule

// ===== rtl/ata_final.sv =====
// Output stage: clamps and rounds the accumulated angles to 1/128 degree,
// applies the special cases and sign, and holds the result word.
// Depends on ata_pkg.
module ata_final (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         valid_i,
  input  ata_pkg::ata_word_t           word_i,
  output logic                         valid_o,
  output logic signed [ata_pkg::OutW-1:0] pitch_o,
  output logic signed [ata_pkg::OutW-1:0] roll_o
);
  import ata_pkg::*;

  function automatic logic signed [OutW-1:0] format(ata_lane_t l);
    logic signed [AngleW-1:0] acl;
    logic signed [AngleW-1:0] sum;
    logic signed [OutW-1:0]   mag;
    acl = l.a;
    if (acl < 0) begin
      acl = '0;
    end else if (acl > AngleMaxQ16) begin
      acl = AngleMaxQ16;
    end
    sum = acl + RoundHalf;
    if (l.zero_num) begin
      mag = '0;
    end else if (l.zero_den) begin
      mag = AngleLimit;
    end else begin
      mag = OutW'(sum[AngleW-2:9]);
    end
    return l.neg ? -mag : mag;
  endfunction

  logic                   valid_q;
  logic signed [OutW-1:0] pitch_q, roll_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pitch_q <= format(word_i.pitch);
      roll_q  <= format(word_i.roll);
    end
  end

  assign valid_o = valid_q;
  assign pitch_o = pitch_q;
  assign roll_o  = roll_q;

endmodule

// ===== rtl/ata_checker.sv =====
// Port-level checker for the accelerometer tilt block, bound to the top.
// Depends on ata_pkg for the output width.
module ata_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_ready_o,
  input logic signed [15:0]              accel_x_i,
  input logic signed [15:0]              accel_y_i,
  input logic signed [15:0]              accel_z_i,
  input logic                            out_valid_o,
  input logic                            out_ready_i,
  input logic signed [ata_pkg::OutW-1:0] pitch_angle_o,
  input logic signed [ata_pkg::OutW-1:0] roll_angle_o
);
  import ata_pkg::*;

  // The input side may only stall when a word sits unclaimed at the output.
  a_stall_only_from_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("input stalled while output side was free");

  // A waiting input word keeps its valid and its payload until taken.
  a_in_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_ready_o) |=> (in_valid_i && $stable(accel_x_i) &&
                                     $stable(accel_y_i) && $stable(accel_z_i)))
    else $error("input word changed before acceptance");

  // Every delivered angle lies within plus or minus 90 degrees.
  a_angle_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (pitch_angle_o >= -AngleLimit && pitch_angle_o <= AngleLimit &&
                     roll_angle_o >= -AngleLimit && roll_angle_o <= AngleLimit))
    else $error("angle outside limit");

  a_out_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> out_valid_o)
    else $error("output word dropped before acceptance");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> ($stable(pitch_angle_o) && $stable(roll_angle_o)))
    else $error("output word changed while stalled");

endmodule

bind accel_tilt_angle_top ata_checker u_ata_checker (.*);

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking bench for accel_tilt_angle_top: pitch and roll from one accelerometer word.
// Depends on ata_pkg and accel_tilt_angle_top; holds its own CORDIC angle predictor.
module testbench;

  localparam int unsigned TiltStages  = ata_pkg::CordicStagesDefault;
  localparam int unsigned StepTableLen = 24;
  localparam int unsigned WordsPerPhase = 106;

  // Arctangent of 2^-i in degrees, Q16. The predictor keeps its own copy so
  // that a wrong entry in the package table is caught rather than repeated.
  localparam longint AtanStepQ16 [StepTableLen] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0
  };

  // Idling schemes that the run steps through.
  typedef enum logic [1:0] {
    IDLE_NONE,
    IDLE_SOURCE_GAPS,
    IDLE_SINK_STALLS,
    IDLE_BOTH
  } idle_mode_e;

  // One directed word. When pinned is set, the angles below were worked out
  // by hand and are used as they stand; otherwise the predictor decides.
  typedef struct packed {
    logic signed [15:0]              x;
    logic signed [15:0]              y;
    logic signed [15:0]              z;
    logic                            pinned;
    logic signed [ata_pkg::OutW-1:0] pitch;
    logic signed [ata_pkg::OutW-1:0] roll;
  } probe_row_t;

  typedef struct packed {
    logic signed [ata_pkg::OutW-1:0] pitch;
    logic signed [ata_pkg::OutW-1:0] roll;
  } tilt_pair_t;

  localparam int unsigned ProbeCount = 20;

  // Directed words: zero numerators, zero z in both signs, full-scale axes,
  // near-vertical and near-flat ratios, and all four sign quadrants.
  localparam probe_row_t ProbeRows [ProbeCount] = '{
    '{16'sd0,      16'sd0,      16'sd0,      1'b1, 15'sd0,      15'sd0},
    '{16'sd0,      16'sd0,      16'sd32767,  1'b1, 15'sd0,      15'sd0},
    '{16'sd0,      16'sd0,     -16'sd32768,  1'b1, 15'sd0,      15'sd0},
    '{16'sd32767, -16'sd32768,  16'sd0,      1'b1, 15'sd11520, -15'sd11520},
    '{-16'sd32768, 16'sd32767,  16'sd0,      1'b1, -15'sd11520, 15'sd11520},
    '{16'sd1,     -16'sd1,      16'sd0,      1'b1, 15'sd11520, -15'sd11520},
    '{16'sd0,      16'sd5,     -16'sd7,      1'b0, 15'sd0,      15'sd0},
    '{16'sd32767,  16'sd32767,  16'sd32767,  1'b0, 15'sd0,      15'sd0},
    '{-16'sd32768, -16'sd32768, -16'sd32768, 1'b0, 15'sd0,      15'sd0},
    '{16'sd32767, -16'sd32768,  16'sd1,      1'b0, 15'sd0,      15'sd0},
    '{-16'sd32768, 16'sd32767, -16'sd1,      1'b0, 15'sd0,      15'sd0},
    '{16'sd1,     -16'sd1,      16'sd32767,  1'b0, 15'sd0,      15'sd0},
    '{16'sd1,     -16'sd1,     -16'sd32768,  1'b0, 15'sd0,      15'sd0},
    '{16'sd100,   -16'sd100,    16'sd100,    1'b0, 15'sd0,      15'sd0},
    '{16'sd16384, -16'sd16384,  16'sd28378,  1'b0, 15'sd0,      15'sd0},
    '{-16'sd1,     16'sd1,     -16'sd1,      1'b0, 15'sd0,      15'sd0},
    '{16'sd12345, -16'sd23456, -16'sd345,    1'b0, 15'sd0,      15'sd0},
    '{16'sd28378,  16'sd16384, -16'sd16384,  1'b0, 15'sd0,      15'sd0},
    '{-16'sd3,     16'sd32767,  16'sd2,      1'b0, 15'sd0,      15'sd0},
    '{16'sd255,   -16'sd256,   -16'sd32767,  1'b0, 15'sd0,      15'sd0}
  };

  localparam idle_mode_e PhasePlan [6] = '{
    IDLE_NONE, IDLE_SOURCE_GAPS, IDLE_SINK_STALLS, IDLE_BOTH,
    IDLE_SOURCE_GAPS, IDLE_SINK_STALLS
  };

  logic                            clk_i       = 1'b0;
  logic                            rst_ni      = 1'b0;
  logic                            in_valid_i  = 1'b0;
  logic                            in_ready_o;
  logic signed [15:0]              accel_x_i   = '0;
  logic signed [15:0]              accel_y_i   = '0;
  logic signed [15:0]              accel_z_i   = '0;
  logic                            out_valid_o;
  logic                            out_ready_i = 1'b0;
  logic signed [ata_pkg::OutW-1:0] pitch_angle_o;
  logic signed [ata_pkg::OutW-1:0] roll_angle_o;

  // Angle pairs predicted for words the block has accepted, oldest first.
  tilt_pair_t angles_due [$];
  int unsigned mismatches = 0;
  idle_mode_e  idle_mode  = IDLE_NONE;

  accel_tilt_angle_top #(
    .CORDIC_STAGES(TiltStages)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .accel_x_i    (accel_x_i),
    .accel_y_i    (accel_y_i),
    .accel_z_i    (accel_z_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .pitch_angle_o(pitch_angle_o),
    .roll_angle_o (roll_angle_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Hard limit on run time, far beyond the slowest legal run.
  initial begin
    #3_000_000;
    $display("[accel_tilt_angle_top] ERROR");
    $finish;
  end

  // atan(num/den) in 1/128 degree. Works on magnitudes with a vectoring
  // CORDIC in Q16 degrees, clamps to [0, 90] degrees, rounds half up, then
  // restores the sign. A zero numerator gives 0 even for 0/0; a zero den
  // gives the full 90 degrees with the numerator's sign.
  function automatic logic signed [ata_pkg::OutW-1:0] tilt_angle(
    input logic signed [15:0] num,
    input logic signed [15:0] den
  );
    longint n;
    longint d;
    longint x;
    longint y;
    longint x_prev;
    longint acc;
    longint mag;
    bit     flip;
    n    = (num < 0) ? -longint'(num) : longint'(num);
    d    = (den < 0) ? -longint'(den) : longint'(den);
    flip = (num < 0) != (den < 0);
    if (n == 0) begin
      mag = 0;
    end else if (d == 0) begin
      mag  = 11520;
      flip = (num < 0);
    end else begin
      x   = d <<< 16;
      y   = n <<< 16;
      acc = 0;
      for (int i = 0; i < TiltStages && i < StepTableLen; i++) begin
        x_prev = x;
        // Arithmetic shifts on signed longint round toward minus infinity.
        if (y >= 0) begin
          x   = x + (y >>> i);
          y   = y - (x_prev >>> i);
          acc = acc + AtanStepQ16[i];
        end else begin
          x   = x - (y >>> i);
          y   = y + (x_prev >>> i);
          acc = acc - AtanStepQ16[i];
        end
      end
      if (acc < 0) acc = 0;
      if (acc > 90 * 65536) acc = 90 * 65536;
      mag = (acc + 256) >>> 9;
      if (mag > 11520) mag = 11520;
    end
    if (flip) mag = -mag;
    return mag[ata_pkg::OutW-1:0];
  endfunction

  function automatic int unsigned source_gap_pct(input idle_mode_e mode);
    case (mode)
      IDLE_SOURCE_GAPS: return 45;
      IDLE_BOTH:        return 8;
      default:          return 0;
    endcase
  endfunction

  function automatic int unsigned sink_stall_pct(input idle_mode_e mode);
    case (mode)
      IDLE_SINK_STALLS: return 45;
      IDLE_BOTH:        return 8;
      default:          return 0;
    endcase
  endfunction

  // One random axis value. Full-range values dominate; small values, zero,
  // the exact extremes and values near full scale give the corner ratios
  // (zero z, zero numerator, near 0 and near 90 degrees) a fair share.
  function automatic logic signed [15:0] draw_axis();
    int unsigned pick;
    int          near;
    pick = $urandom_range(0, 99);
    near = int'($urandom_range(32512, 32767));
    if (pick < 45) return 16'($urandom);
    if (pick < 65) return 16'(int'($urandom_range(0, 128)) - 64);
    if (pick < 75) return '0;
    if (pick < 87) begin
      case ($urandom_range(0, 3))
        0:       return 16'sd32767;
        1:       return -16'sd32768;
        2:       return 16'sd1;
        default: return -16'sd1;
      endcase
    end
    return ($urandom_range(0, 1) != 0) ? 16'(near) : 16'(-near - 1);
  endfunction

  // One line per mismatch, and the count goes up.
  task automatic flag_mismatch(input string what, input int got, input int want);
    mismatches++;
    $display("%0t: mismatch in %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  // Offers one word to the block and waits for it to be taken. Source gaps
  // are inserted ahead of the word according to the current idle scheme;
  // when there is no gap, valid simply stays high for the next word.
  task automatic send_word(
    input logic signed [15:0] x,
    input logic signed [15:0] y,
    input logic signed [15:0] z,
    input logic               pinned,
    input tilt_pair_t         pinned_pair
  );
    tilt_pair_t want;
    while ($urandom_range(0, 99) < source_gap_pct(idle_mode)) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    accel_x_i  <= x;
    accel_y_i  <= y;
    accel_z_i  <= z;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (pinned) begin
      want = pinned_pair;
    end else begin
      want.pitch = tilt_angle(x, z);
      want.roll  = tilt_angle(y, z);
    end
    angles_due.push_back(want);
  endtask

  // Holds the source off until every predicted pair has come back.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (angles_due.size() != 0) @(posedge clk_i);
  endtask

  // Result side: every word taken from the block is compared with the
  // oldest prediction, then ready is chosen for the next cycle.
  initial begin
    tilt_pair_t want;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) begin
        if (angles_due.size() == 0) begin
          flag_mismatch("unexpected word, pitch", int'(pitch_angle_o), 0);
        end else begin
          want = angles_due.pop_front();
          if (pitch_angle_o !== want.pitch) begin
            flag_mismatch("pitch_angle", int'(pitch_angle_o), int'(want.pitch));
          end
          if (roll_angle_o !== want.roll) begin
            flag_mismatch("roll_angle", int'(roll_angle_o), int'(want.roll));
          end
        end
      end
      out_ready_i <= ($urandom_range(0, 99) >= sink_stall_pct(idle_mode));
    end
  end

  // Source side: reset, the directed table, then random words under each
  // idle scheme in turn. Between schemes the source waits for the pipeline
  // to empty, which also covers the case of a fully drained block.
  initial begin
    probe_row_t row;
    tilt_pair_t pair;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    idle_mode = IDLE_NONE;
    for (int r = 0; r < ProbeCount; r++) begin
      row        = ProbeRows[r];
      pair.pitch = row.pitch;
      pair.roll  = row.roll;
      send_word(row.x, row.y, row.z, row.pinned, pair);
    end
    drain_results();

    pair = '0;
    foreach (PhasePlan[p]) begin
      idle_mode = PhasePlan[p];
      for (int k = 0; k < WordsPerPhase; k++) begin
        send_word(draw_axis(), draw_axis(), draw_axis(), 1'b0, pair);
      end
      drain_results();
    end

    // Give any stray word time to appear before the verdict.
    idle_mode = IDLE_NONE;
    repeat (TiltStages + 8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("[accel_tilt_angle_top] OK");
    end else begin
      $display("[accel_tilt_angle_top] ERROR");
    end
    $finish;
  end

endmodule
